// ===== hdl/sad_pkg.sv =====
// shared types and constants for the sprite attribute decoder
package sad_pkg;

    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    // register indexes, the byte address is the index times four
    localparam logic [1:0] RegOlderFormat  = 2'd0;
    localparam logic [1:0] RegBankVariant  = 2'd1;
    localparam logic [1:0] RegExtraBank    = 2'd2;

    // bank extension variants
    localparam logic [1:0] VariantNone     = 2'd0;
    localparam logic [1:0] VariantAddFour  = 2'd1;
    localparam logic [1:0] VariantExtend   = 2'd2;

    // size codes taken from the top two code bits in the newer format
    localparam logic [1:0] SizeSmall       = 2'b00;
    localparam logic [1:0] SizeFourByFour  = 2'b01;
    localparam logic [1:0] SizeTall        = 2'b10;
    localparam logic [1:0] SizeTallWide    = 2'b11;

    typedef struct packed {
        logic       start_of_list;
        logic [7:0] y_byte;
        logic [7:0] code_byte;
        logic [7:0] x_byte;
        logic [7:0] bank_byte;
    } sad_req_t;

    typedef struct packed {
        logic [2:0]        source_page;
        logic [4:0]        source_column;
        logic [4:0]        source_row;
        logic [2:0]        width_tiles;
        logic [5:0]        height_tiles;
        logic              mirror_x;
        logic              mirror_y;
        logic [5:0]        tile_bank;
        logic              colour_bank;
        logic signed [15:0] screen_x;
        logic [7:0]        screen_y;
    } sad_res_t;

    typedef struct packed {
        logic       older_format;
        logic [1:0] bank_variant;
        logic [3:0] extra_tile_bank;
    } sad_cfg_t;

endpackage

// ===== hdl/sad_cfg.sv =====
// apb configuration registers
module sad_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sad_pkg::AddrWidth-1:0] paddr,
    input  logic [sad_pkg::DataWidth-1:0] pwdata,
    output logic [sad_pkg::DataWidth-1:0] prdata,
    output logic                         pready,
    output sad_pkg::sad_cfg_t            cfg
);
    import sad_pkg::*;

    sad_cfg_t  cfg_reg;
    sad_cfg_t  cfg_next;
    logic      wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[AddrWidth-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                RegOlderFormat: cfg_next.older_format    = pwdata[0];
                RegBankVariant: cfg_next.bank_variant    = pwdata[1:0];
                RegExtraBank:   cfg_next.extra_tile_bank = pwdata[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            RegOlderFormat: prdata[0]   = cfg_reg.older_format;
            RegBankVariant: prdata[1:0] = cfg_reg.bank_variant;
            RegExtraBank:   prdata[3:0] = cfg_reg.extra_tile_bank;
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/sad_decode.sv =====
// decode of one sprite entry and next multisprite chain position
module sad_decode (
    input  sad_pkg::sad_req_t req,
    input  sad_pkg::sad_cfg_t cfg,
    input  logic [15:0]       chain_x,
    output sad_pkg::sad_res_t res,
    output logic [15:0]       chain_x_next
);
    import sad_pkg::*;

    logic [7:0]  code;
    logic [7:0]  bank;
    logic        multi;
    logic [15:0] chain_base;
    logic [15:0] own_x;
    logic [7:0]  h_pixels;
    logic [5:0]  ext_bank;

    assign code = req.code_byte;
    assign bank = req.bank_byte;

    // bank three may be pushed up by the extra bank register
    always_comb
    begin
        if (cfg.bank_variant == VariantExtend && bank[1:0] == 2'b11)
            ext_bank = 6'd3 + {2'b00, cfg.extra_tile_bank};
        else
            ext_bank = {4'b0000, bank[1:0]};
    end

    always_comb
    begin
        res = '0;
        multi = 1'b0;
        if (cfg.older_format)
        begin
            res.tile_bank     = bank[5:0];
            res.width_tiles   = 3'd2;
            res.source_column = {code[3:0], 1'b0};
            if (code[7])
            begin
                res.height_tiles = 6'd32;
                res.source_page  = {1'b0, code[5:4]};
            end
            else
            begin
                res.height_tiles = 6'd2;
                res.source_row   = {code[6:5], 3'b110};
                res.source_page  = {2'b00, code[4]};
            end
            multi = code[7] & code[6];
        end
        else
        begin
            case (code[7:6])
                SizeTallWide:
                begin
                    res.width_tiles   = 3'd4;
                    res.height_tiles  = 6'd32;
                    res.source_column = {code[3:1], 2'b00};
                    res.mirror_x      = code[0];
                    res.tile_bank     = {1'b0, bank[4:0]};
                    res.source_page   = {1'b0, code[5:4]};
                end
                SizeTall:
                begin
                    res.width_tiles   = 3'd2;
                    res.height_tiles  = 6'd32;
                    res.source_column = {code[3:0], 1'b0};
                    res.tile_bank     = {1'b0, bank[4:0]};
                    res.source_page   = {1'b0, code[5:4]};
                end
                SizeFourByFour:
                begin
                    res.width_tiles   = 3'd4;
                    res.height_tiles  = 6'd4;
                    res.source_column = {code[3:1], 2'b00};
                    res.mirror_x      = code[0];
                    res.mirror_y      = bank[4];
                    res.source_row    = {bank[7], bank[2], ~bank[5], 2'b00};
                    res.source_page   = {1'b1, code[5:4]};
                    res.colour_bank   = bank[3];
                    if (cfg.bank_variant == VariantAddFour)
                        res.tile_bank = {3'b000, 1'b1, bank[1:0]};
                    else
                        res.tile_bank = ext_bank;
                end
                default:
                begin
                    res.width_tiles   = 3'd2;
                    res.height_tiles  = 6'd2;
                    res.source_column = {code[3:0], 1'b0};
                    res.source_row    = {bank[7], bank[2], ~bank[5], ~bank[4], 1'b0};
                    res.source_page   = {1'b0, code[5:4]};
                    res.tile_bank     = ext_bank;
                end
            endcase
            multi = code[7] & bank[7];
        end

        // 8 * height, only the low byte matters for the wrapped y
        h_pixels = {res.height_tiles[4:0], 3'b000};
        res.screen_y = 8'd0 - req.y_byte - h_pixels;

        chain_base = req.start_of_list ? 16'd0 : chain_x;
        own_x      = {{8{bank[6]}}, req.x_byte};
        if (multi)
            chain_x_next = chain_base + {10'd0, res.width_tiles, 3'b000};
        else
            chain_x_next = own_x;
        res.screen_x = chain_x_next;
    end

endmodule

// ===== hdl/sprite_attribute_decoder.sv =====
// top level of the sprite attribute decoder
// each request passes the input register and then the output register, one request per
// cycle while the output is not stalled; the chain x update is combinational; a request
// is taken while a finished result waits if the input register is empty, the input
// register parts the two sides; reset clears the valid flags, the chain x counter and all
// configuration registers; payload registers are not reset
module sprite_attribute_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sad_pkg::AddrWidth-1:0] paddr,
    input  logic [sad_pkg::DataWidth-1:0] pwdata,
    output logic [sad_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sad_pkg::sad_req_t             req_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output sad_pkg::sad_res_t             res_data
);
    import sad_pkg::*;

    sad_cfg_t    cfg;
    logic        in_valid_reg;
    logic        in_valid_next;
    sad_req_t    in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    sad_res_t    out_data_reg;
    logic [15:0] chain_x_reg;
    logic [15:0] chain_x_next;
    sad_res_t    dec_res;
    logic        out_free;
    logic        move;
    logic        take;

    sad_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sad_decode u_decode (
        .req          (in_data_reg),
        .cfg          (cfg),
        .chain_x      (chain_x_reg),
        .res          (dec_res),
        .chain_x_next (chain_x_next)
    );

    assign out_free  = !out_valid_reg || !res_stall;
    assign move      = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign take      = req_valid && !req_stall;

    assign in_valid_next  = take || (in_valid_reg && !move);
    assign out_valid_next = move || (out_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_x_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (move)
                chain_x_reg <= chain_x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= req_data;
        if (move)
            out_data_reg <= dec_res;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

// ===== hdl/sad_checker.sv =====
// port level checks for the sprite attribute decoder, bound to the top level
module sad_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          res_valid,
    input logic                          res_stall,
    input sad_pkg::sad_res_t             res_data
);

    // a held result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // with the output empty the request side is never stalled
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !req_stall)
        else $error("request stalled with empty output");

    // a request taken while the output is empty is followed by a result through the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !res_valid |=> ##1 res_valid)
        else $error("result missing after request");

    // only the legal sprite sizes come out
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.width_tiles == 3'd2 || res_data.width_tiles == 3'd4)
                   && (res_data.height_tiles == 6'd2 || res_data.height_tiles == 6'd4
                       || res_data.height_tiles == 6'd32))
        else $error("illegal sprite size");

endmodule

bind sprite_attribute_decoder sad_checker u_sad_checker (.*);
